// File: sv/dibp_pkg.sv
// Shared types, register codes and fixed-point helpers for the depth
// back-projection block. No dependencies.
package dibp_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_FOCAL_X     = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [2:0] REG_CENTER_X    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y    = 3'd3;
    localparam logic [2:0] REG_DEPTH_MAX   = 3'd4;
    localparam logic [2:0] REG_DEPTH_MIN   = 3'd5;
    localparam logic [2:0] REG_DEPTH_SCALE = 3'd6;
    localparam logic [2:0] REG_EDGE_MARGIN = 3'd7;

    // Register reset values.
    localparam logic [30:0] RST_FOCAL       = 31'd65536;
    localparam logic [30:0] RST_CENTER      = 31'd0;
    localparam logic [30:0] RST_DEPTH_MAX   = 31'd327680;
    localparam logic [30:0] RST_DEPTH_MIN   = 31'd6554;
    localparam logic [31:0] RST_DEPTH_SCALE = 32'd16777;
    localparam logic [7:0]  RST_EDGE_MARGIN = 8'd0;

    // Pose word slots.
    localparam int         POSE_WORDS = 7;
    localparam logic [2:0] SLOT_QW    = 3'd0;
    localparam logic [2:0] SLOT_QX    = 3'd1;
    localparam logic [2:0] SLOT_QY    = 3'd2;
    localparam logic [2:0] SLOT_QZ    = 3'd3;
    localparam logic [2:0] SLOT_PX    = 3'd4;
    localparam logic [2:0] SLOT_PY    = 3'd5;
    localparam logic [2:0] SLOT_PZ    = 3'd6;
    localparam logic [2:0] SLOT_NONE  = 3'd7;

    localparam logic signed [31:0] Q16_ONE = 32'sd65536;

    // Queue between front and back, and the divider pipeline.
    localparam int QDEPTH    = 4;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 3;

    typedef struct packed {
        logic [30:0] focal_x;
        logic [30:0] focal_y;
        logic [30:0] center_x;
        logic [30:0] center_y;
        logic [30:0] depth_max;
        logic [30:0] depth_min;
        logic [31:0] depth_scale;
        logic [7:0]  edge_margin;
    } t_cfg;

    // One classified item on its way from front to back.
    typedef struct packed {
        logic               is_pose;
        logic [9:0]         col;
        logic [8:0]         row_idx;
        logic [30:0]        depth;
        logic [2:0]         pose_slot;
        logic signed [31:0] pose_value;
    } t_job;

    // Round a Q16.16 x Q16.16 product to Q16.16, floor after adding one half.
    function automatic logic signed [48:0] rnd_q16(input logic signed [64:0] p);
        logic signed [64:0] t;
        t = p + 65'sd32768;
        return $signed(t[64:16]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/depth_image_to_world_points.sv
// Top level of the depth back-projection block: configuration registers,
// front end, job queue and back end. Uses dibp_pkg and all dibp_* modules.
//
// The block takes one beat per clock while s_axis_tready is high. A beat is
// a depth pixel or a pose word (tuser = 1). Pixels off the margin/skip grid
// or nearer than depth_min give no point; zero or far depths clamp to
// depth_max. Each kept pixel is back-projected through the pinhole intrinsics,
// rotated by the matrix built from the stored quaternion, translated by the
// position and sent out as one Q16.16 world point. Sustained rate is one pixel
// per clock unless the output stalls or a pose word is applied; the two
// projection divides use 32-step quotient pipelines. Every pose word holds
// the back end while the quaternion products and the matrix are rebuilt; pose
// words take effect strictly in beat order. Configuration is written on its own
// channel, always ready; the user must write it only while the block is idle.
module depth_image_to_world_points #(
    parameter int IMG_W = 640,
    parameter int IMG_H = 480,
    parameter int SKIP  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] col, [18:10] row_idx, [34:19] raw_depth, [37:35] pose_slot,
    // [69:38] pose_value, [71:70] zero
    input  logic [71:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] point_z
    output logic [95:0] m_axis_tdata
);
    dibp_pkg::t_cfg r_cfg;
    dibp_pkg::t_job front_job, queue_job;
    logic push, full, pop, empty;
    logic signed [31:0] pt_x, pt_y, pt_z;

    assign o_cfg_ready = 1'b1;

    // Register writes; data above a register's width is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x     <= dibp_pkg::RST_FOCAL;
            r_cfg.focal_y     <= dibp_pkg::RST_FOCAL;
            r_cfg.center_x    <= dibp_pkg::RST_CENTER;
            r_cfg.center_y    <= dibp_pkg::RST_CENTER;
            r_cfg.depth_max   <= dibp_pkg::RST_DEPTH_MAX;
            r_cfg.depth_min   <= dibp_pkg::RST_DEPTH_MIN;
            r_cfg.depth_scale <= dibp_pkg::RST_DEPTH_SCALE;
            r_cfg.edge_margin <= dibp_pkg::RST_EDGE_MARGIN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dibp_pkg::REG_FOCAL_X:     r_cfg.focal_x     <= i_cfg_data[30:0];
                dibp_pkg::REG_FOCAL_Y:     r_cfg.focal_y     <= i_cfg_data[30:0];
                dibp_pkg::REG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[30:0];
                dibp_pkg::REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[30:0];
                dibp_pkg::REG_DEPTH_MAX:   r_cfg.depth_max   <= i_cfg_data[30:0];
                dibp_pkg::REG_DEPTH_MIN:   r_cfg.depth_min   <= i_cfg_data[30:0];
                dibp_pkg::REG_DEPTH_SCALE: r_cfg.depth_scale <= i_cfg_data;
                dibp_pkg::REG_EDGE_MARGIN: r_cfg.edge_margin <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Classify beats and filter depth.
    dibp_front #(.IMG_W(IMG_W), .IMG_H(IMG_H), .SKIP(SKIP)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tuser[0]),
        .i_col        (s_axis_tdata[9:0]),
        .i_row_idx    (s_axis_tdata[18:10]),
        .i_raw_depth  (s_axis_tdata[34:19]),
        .i_pose_slot  (s_axis_tdata[37:35]),
        .i_pose_value ($signed(s_axis_tdata[69:38])),
        .o_push       (push),
        .o_job        (front_job),
        .i_full       (full)
    );

    // Decouple front stalls from back stalls.
    dibp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (queue_job)
    );

    // Project, rotate, translate; apply pose words in order.
    dibp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_job     (queue_job),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_point_x (pt_x),
        .o_point_y (pt_y),
        .o_point_z (pt_z)
    );

    assign m_axis_tdata = {pt_z, pt_y, pt_x};
endmodule

// File: sv/dibp_queue.sv
// Short job queue between the front and the back of the block.
// Depends on dibp_pkg for the job type and depth.
module dibp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dibp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dibp_pkg::t_job o_job
);
    localparam int PTR_W = $clog2(dibp_pkg::QDEPTH);
    localparam int CNT_W = $clog2(dibp_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(dibp_pkg::QDEPTH);

    dibp_pkg::t_job r_mem [0:dibp_pkg::QDEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule

// File: sv/dibp_front.sv
// Front end: accepts beats, checks the pixel grid, scales and range-filters
// the depth, and pushes pose words and kept pixels into the queue. Uses dibp_pkg.
module dibp_front #(
    parameter int IMG_W = 640,
    parameter int IMG_H = 480,
    parameter int SKIP  = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dibp_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [9:0]         i_col,
    input  logic [8:0]         i_row_idx,
    input  logic [15:0]        i_raw_depth,
    input  logic [2:0]         i_pose_slot,
    input  logic signed [31:0] i_pose_value,
    output logic               o_push,
    output dibp_pkg::t_job     o_job,
    input  logic               i_full
);
    // (p - margin) mod SKIP through a reciprocal and one correction step.
    localparam int          RECIP   = (1 << 16) / SKIP;
    localparam logic [16:0] RECIP_C = 17'(RECIP);
    localparam logic [3:0]  SKIP_C  = 4'(SKIP);
    localparam logic [12:0] W_C     = 13'(IMG_W);
    localparam logic [12:0] H_C     = 13'(IMG_H);

    function automatic logic on_grid(input logic [9:0] p, input logic [7:0] m,
                                     input logic [12:0] size);
        logic [9:0]  x;
        logic [26:0] prod;
        logic [10:0] q;
        logic [14:0] qs;
        logic [14:0] r;
        logic        in_rng;
        x      = p - {2'b0, m};
        prod   = {17'b0, x} * {10'b0, RECIP_C};
        q      = prod[26:16];
        qs     = {4'b0, q} * {11'b0, SKIP_C};
        r      = {5'b0, x} - qs;
        in_rng = (p >= {2'b0, m}) && (({3'b0, p} + {5'b0, m}) < size);
        return in_rng && ((r == 15'd0) || (r == {11'b0, SKIP_C}));
    endfunction

    logic               r_valid, r_cmd, r_grid;
    logic [9:0]         r_col;
    logic [8:0]         r_row;
    logic [15:0]        r_raw;
    logic [2:0]         r_slot;
    logic signed [31:0] r_value;
    logic [47:0]        r_prod;

    logic [47:0] rnd;
    logic [39:0] dep;
    logic        far, near, keep, en;

    always_comb begin
        rnd  = r_prod + 48'd128;
        dep  = rnd[47:8];
        far  = (r_raw == 16'd0) || (dep > {9'b0, i_cfg.depth_max});
        near = dep < {9'b0, i_cfg.depth_min};
        keep = r_cmd || (r_grid && (far || !near));
        en   = !r_valid || !keep || !i_full;
    end

    assign o_ready = en;
    assign o_push  = r_valid && keep && !i_full;

    always_comb begin
        o_job.is_pose    = r_cmd;
        o_job.col        = r_col;
        o_job.row_idx    = r_row;
        o_job.depth      = far ? i_cfg.depth_max : dep[30:0];
        o_job.pose_slot  = r_slot;
        o_job.pose_value = r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd   <= i_command;
            r_col   <= i_col;
            r_row   <= i_row_idx;
            r_raw   <= i_raw_depth;
            r_slot  <= i_pose_slot;
            r_value <= i_pose_value;
            r_grid  <= on_grid(i_col, i_cfg.edge_margin, W_C)
                    && on_grid({1'b0, i_row_idx}, i_cfg.edge_margin, H_C);
            r_prod  <= {32'b0, i_raw_depth} * {16'b0, i_cfg.depth_scale};
        end
    end
endmodule

// File: sv/dibp_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating to 32 bits. Uses dibp_pkg for the step count.
module dibp_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [62:0] i_num,
    input  logic [30:0]        i_den,
    output logic signed [31:0] o_quot
);
    localparam int STEPS = dibp_pkg::DIV_STEPS;

    logic        r_neg0;
    logic [61:0] r_mag;
    logic [30:0] r_den0;
    logic [62:0] mag_full;

    logic        r_neg [0:STEPS];
    logic        r_ovf [0:STEPS];
    logic [30:0] r_den [0:STEPS];
    logic [30:0] r_rem [0:STEPS];
    logic [31:0] r_lo  [0:STEPS];

    assign mag_full = i_num[62] ? -i_num : i_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0   <= i_num[62];
            r_mag    <= mag_full[61:0];
            r_den0   <= i_den;
            // quotient beyond 32 bits saturates
            r_ovf[0] <= {1'b0, r_mag[61:32]} >= r_den0;
            r_neg[0] <= r_neg0;
            r_den[0] <= r_den0;
            r_rem[0] <= {1'b0, r_mag[61:32]};
            r_lo[0]  <= r_mag[31:0];
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [31:0] trial, diff;
        logic        ge;
        assign trial = {r_rem[k-1], r_lo[k-1][31]};
        assign diff  = trial - {1'b0, r_den[k-1]};
        assign ge    = trial >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[30:0] : trial[30:0];
                r_lo[k]  <= {r_lo[k-1][30:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[STEPS]) begin
                o_quot <= (r_ovf[STEPS] || (r_lo[STEPS] > 32'h8000_0000))
                        ? 32'sh8000_0000 : -$signed(r_lo[STEPS]);
            end else begin
                o_quot <= (r_ovf[STEPS] || r_lo[STEPS][31])
                        ? 32'sh7fff_ffff : $signed(r_lo[STEPS]);
            end
        end
    end
endmodule

// File: sv/dibp_back.sv
// Back end: projects queued pixels through the intrinsics, rotates and
// translates them, and applies pose words in order. Uses dibp_pkg, dibp_div.
module dibp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dibp_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    output logic               o_pop,
    input  dibp_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);
    localparam int LAT = dibp_pkg::DIV_LAT;
    localparam logic [1:0] DRV_IDLE = 2'd0;
    localparam logic [1:0] DRV_MAT  = 2'd1;
    localparam logic [1:0] DRV_PROD = 2'd2;

    typedef struct packed {
        logic               is_pose;
        logic [30:0]        depth;
        logic [2:0]         pose_slot;
        logic signed [31:0] pose_value;
    } t_side;

    logic [1:0] r_drv;
    logic       en_all, en_m;

    // stage A: offsets from the principal point
    logic               r_a_valid;
    t_side              r_a_side;
    logic signed [31:0] r_a_dx, r_a_dy;
    logic signed [32:0] dx, dy;

    // stage B: numerators
    logic               r_b_valid;
    t_side              r_b_side;
    logic signed [62:0] r_b_nx, r_b_ny;
    logic signed [63:0] px, py;
    logic [30:0]        den_x, den_y;

    logic               r_sb_valid [0:LAT-1];
    t_side              r_sb_side  [0:LAT-1];
    logic signed [31:0] qx, qy;

    logic               m_valid;
    t_side              m_side;
    logic signed [32:0] mid [0:2];

    logic               r_p_valid;
    logic signed [64:0] r_p [0:8];

    logic signed [31:0] r_pose [0:dibp_pkg::POSE_WORDS-1];
    logic signed [31:0] r_mat  [0:8];
    logic signed [63:0] r_qp   [0:8];
    logic signed [51:0] qe     [0:8];
    logic signed [51:0] pe     [0:8];
    logic signed [51:0] acc    [0:2];

    assign en_all  = !o_valid || i_ready;
    assign en_m    = en_all && (r_drv == DRV_IDLE);
    assign o_pop   = en_m && !i_empty;
    assign m_valid = r_sb_valid[LAT-1];
    assign m_side  = r_sb_side[LAT-1];

    always_comb begin
        dx    = $signed({7'b0, i_job.col, 16'b0}) - $signed({2'b0, i_cfg.center_x});
        dy    = $signed({8'b0, i_job.row_idx, 16'b0}) - $signed({2'b0, i_cfg.center_y});
        px    = r_a_dx * $signed({1'b0, r_a_side.depth});
        py    = r_a_dy * $signed({1'b0, r_a_side.depth});
        den_x = (i_cfg.focal_x == 31'd0) ? 31'd1 : i_cfg.focal_x;
        den_y = (i_cfg.focal_y == 31'd0) ? 31'd1 : i_cfg.focal_y;
        mid[0] = $signed({2'b0, m_side.depth});
        mid[1] = -$signed({qx[31], qx});
        mid[2] = -$signed({qy[31], qy});
    end

    dibp_div u_div_x (.i_clk(i_clk), .i_en(en_m), .i_num(r_b_nx), .i_den(den_x),
                      .o_quot(qx));
    dibp_div u_div_y (.i_clk(i_clk), .i_en(en_m), .i_num(r_b_ny), .i_den(den_y),
                      .o_quot(qy));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_p_valid <= 1'b0;
            o_valid   <= 1'b0;
            for (int k = 0; k < LAT; k++) begin
                r_sb_valid[k] <= 1'b0;
            end
        end else begin
            if (en_m) begin
                r_a_valid     <= o_pop;
                r_b_valid     <= r_a_valid;
                r_sb_valid[0] <= r_b_valid;
                for (int k = 1; k < LAT; k++) begin
                    r_sb_valid[k] <= r_sb_valid[k-1];
                end
            end
            if (en_all) begin
                // bubble into the product stage while the matrix is rebuilt
                r_p_valid <= en_m && m_valid && !m_side.is_pose;
                o_valid   <= r_p_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en_m) begin
            r_a_side.is_pose    <= i_job.is_pose;
            r_a_side.depth      <= i_job.depth;
            r_a_side.pose_slot  <= i_job.pose_slot;
            r_a_side.pose_value <= i_job.pose_value;
            r_a_dx              <= dx[31:0];
            r_a_dy              <= dy[31:0];
            r_b_side            <= r_a_side;
            r_b_nx              <= $signed(px[62:0]);
            r_b_ny              <= $signed(py[62:0]);
            r_sb_side[0]        <= r_b_side;
            for (int k = 1; k < LAT; k++) begin
                r_sb_side[k] <= r_sb_side[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[3*i+j] <= r_mat[3*i+j] * mid[j];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            pe[k] = dibp_pkg::rnd_q16(r_p[k]);
            qe[k] = dibp_pkg::rnd_q16({r_qp[k][63], r_qp[k]});
        end
        for (int i = 0; i < 3; i++) begin
            acc[i] = r_pose[4+i] + pe[3*i] + pe[3*i+1] + pe[3*i+2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_all && r_p_valid) begin
            o_point_x <= dibp_pkg::sat32(acc[0]);
            o_point_y <= dibp_pkg::sat32(acc[1]);
            o_point_z <= dibp_pkg::sat32(acc[2]);
        end
    end

    // pose words and rotation matrix; a pose word stalls the pipe while the products and matrix are rebuilt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drv <= DRV_IDLE;
            for (int k = 0; k < dibp_pkg::POSE_WORDS; k++) begin
                r_pose[k] <= '0;
            end
            r_pose[dibp_pkg::SLOT_QW] <= dibp_pkg::Q16_ONE;
            for (int k = 0; k < 9; k++) begin
                r_mat[k] <= ((k % 4) == 0) ? dibp_pkg::Q16_ONE : 32'sd0;
            end
        end else begin
            if (en_m && m_valid && m_side.is_pose) begin
                if (m_side.pose_slot != dibp_pkg::SLOT_NONE) begin
                    r_pose[m_side.pose_slot] <= m_side.pose_value;
                end
                r_drv <= DRV_PROD;
            end else if (r_drv != DRV_IDLE) begin
                r_drv <= r_drv - 2'd1;
            end
            if (r_drv == DRV_MAT) begin
                // order: xx yy zz xy xz yz wx wy wz
                r_mat[0] <= dibp_pkg::sat32(52'sd65536 - 52'sd2 * (qe[1] + qe[2]));
                r_mat[1] <= dibp_pkg::sat32(52'sd2 * (qe[3] - qe[8]));
                r_mat[2] <= dibp_pkg::sat32(52'sd2 * (qe[4] + qe[7]));
                r_mat[3] <= dibp_pkg::sat32(52'sd2 * (qe[3] + qe[8]));
                r_mat[4] <= dibp_pkg::sat32(52'sd65536 - 52'sd2 * (qe[0] + qe[2]));
                r_mat[5] <= dibp_pkg::sat32(52'sd2 * (qe[5] - qe[6]));
                r_mat[6] <= dibp_pkg::sat32(52'sd2 * (qe[4] - qe[7]));
                r_mat[7] <= dibp_pkg::sat32(52'sd2 * (qe[5] + qe[6]));
                r_mat[8] <= dibp_pkg::sat32(52'sd65536 - 52'sd2 * (qe[0] + qe[1]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_drv == DRV_PROD) begin
            r_qp[0] <= r_pose[dibp_pkg::SLOT_QX] * r_pose[dibp_pkg::SLOT_QX];
            r_qp[1] <= r_pose[dibp_pkg::SLOT_QY] * r_pose[dibp_pkg::SLOT_QY];
            r_qp[2] <= r_pose[dibp_pkg::SLOT_QZ] * r_pose[dibp_pkg::SLOT_QZ];
            r_qp[3] <= r_pose[dibp_pkg::SLOT_QX] * r_pose[dibp_pkg::SLOT_QY];
            r_qp[4] <= r_pose[dibp_pkg::SLOT_QX] * r_pose[dibp_pkg::SLOT_QZ];
            r_qp[5] <= r_pose[dibp_pkg::SLOT_QY] * r_pose[dibp_pkg::SLOT_QZ];
            r_qp[6] <= r_pose[dibp_pkg::SLOT_QW] * r_pose[dibp_pkg::SLOT_QX];
            r_qp[7] <= r_pose[dibp_pkg::SLOT_QW] * r_pose[dibp_pkg::SLOT_QY];
            r_qp[8] <= r_pose[dibp_pkg::SLOT_QW] * r_pose[dibp_pkg::SLOT_QZ];
        end
    end
endmodule
